// ===== rtl/hll_pkg.sv =====
package hll_pkg;

    localparam int INDEX_BITS = 14;
    localparam int M          = 1 << INDEX_BITS;
    localparam int REM_W      = 32 - INDEX_BITS;
    localparam int RANK_W     = 5;
    localparam int SUM_W      = INDEX_BITS + 33;
    localparam int ZCNT_W     = INDEX_BITS + 1;
    localparam int HSUM_W     = 47;
    localparam int ZOUT_W     = 15;
    localparam int EST_W      = 33;
    localparam int NUM_W      = 64;
    localparam int DCNT_W     = $clog2(NUM_W);

    localparam int SUM_XW  = (SUM_W > HSUM_W) ? SUM_W : HSUM_W;
    localparam int ZCNT_XW = (ZCNT_W > ZOUT_W) ? ZCNT_W : ZOUT_W;

    localparam logic [1:0] ACT_ADD   = 2'd0;
    localparam logic [1:0] ACT_QUERY = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [RANK_W-1:0] RANK_CLAMP = RANK_W'(29);
    localparam logic [RANK_W-1:0] RANK_NONE  = RANK_W'(33 - INDEX_BITS);

    localparam logic [HSUM_W-1:0] HSUM_MAX = '1;
    localparam logic [ZOUT_W-1:0] ZOUT_MAX = '1;
    localparam logic [EST_W-1:0]  EST_MAX  = '1;
    localparam logic [EST_W-1:0]  LIN_LIMIT = EST_W'((5 * M) / 2);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_LAST,
        ST_DSTART,
        ST_DIV
    } state_t;

    // floor(coef * 2^shifts / den) by shift and subtract
    function automatic longint unsigned div_pow2(longint unsigned coef, int shifts,
                                                 longint unsigned den);
        longint unsigned r;
        longint unsigned q;
        longint unsigned b;
        r = 0;
        q = 0;
        for (int i = 0; i < 16 + shifts; i++)
        begin
            b = (i < 16) ? ((coef >> (15 - i)) & 64'd1) : 64'd0;
            r = (r << 1) | b;
            q = q << 1;
            if (r >= den)
            begin
                r = r - den;
                q = q | 64'd1;
            end
        end
        return q;
    endfunction

    function automatic longint unsigned alpha_mm_q16();
        longint unsigned m;
        longint unsigned res;
        m = longint'(M);
        if (M == 16)
            res = div_pow2(673, 2 * INDEX_BITS + 16, 1000);
        else if (M == 32)
            res = div_pow2(697, 2 * INDEX_BITS + 16, 1000);
        else if (M == 64)
            res = div_pow2(709, 2 * INDEX_BITS + 16, 1000);
        else
            res = div_pow2(7213, 3 * INDEX_BITS + 16, 10 * (1000 * m + 1079));
        return res;
    endfunction

    localparam logic [NUM_W-1:0] DIV_NUM = NUM_W'(alpha_mm_q16() << 16);

    // rank of the bits below the index: leading zeros plus one
    function automatic logic [RANK_W-1:0] rank_of(logic [31:0] h);
        logic [RANK_W-1:0] r;
        r = RANK_NONE;
        for (int i = 0; i < REM_W; i++)
        begin
            if (h[i])
                r = RANK_W'(REM_W - i);
        end
        return r;
    endfunction

    function automatic logic [SUM_W-1:0] term_of(logic [RANK_W-1:0] r);
        logic [RANK_W-1:0] rc;
        rc = (r > RANK_CLAMP) ? RANK_CLAMP : r;
        return SUM_W'(64'd1 << (32 - int'(rc)));
    endfunction

endpackage

// ===== rtl/hll_divider.sv =====
module hll_divider (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [hll_pkg::SUM_W-1:0]    den,
    output logic                         done,
    output logic [hll_pkg::EST_W-1:0]    quotient
);

    logic                          run_reg;
    logic                          done_reg;
    logic [hll_pkg::DCNT_W-1:0]    cnt_reg;
    logic [hll_pkg::SUM_W-1:0]     rem_reg;
    logic [hll_pkg::SUM_W-1:0]     rem_next;
    logic [hll_pkg::NUM_W-1:0]     num_reg;
    logic [hll_pkg::NUM_W-1:0]     quo_reg;
    logic [hll_pkg::SUM_W:0]       trial;
    logic [hll_pkg::SUM_W:0]       diff;
    logic                          ge;
    logic                          last;
    logic                          sat;

    always_comb
    begin
        trial    = {rem_reg, num_reg[hll_pkg::NUM_W-1]};
        ge       = trial >= {1'b0, den};
        diff     = trial - {1'b0, den};
        rem_next = ge ? diff[hll_pkg::SUM_W-1:0] : trial[hll_pkg::SUM_W-1:0];
        last     = cnt_reg == hll_pkg::DCNT_W'(hll_pkg::NUM_W - 1);
        sat      = |quo_reg[hll_pkg::NUM_W-1:hll_pkg::EST_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            num_reg <= hll_pkg::DIV_NUM;
            quo_reg <= '0;
        end
        else if (run_reg)
        begin
            rem_reg <= rem_next;
            num_reg <= {num_reg[hll_pkg::NUM_W-2:0], 1'b0};
            quo_reg <= {quo_reg[hll_pkg::NUM_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = (den == '0 || sat) ? hll_pkg::EST_MAX : quo_reg[hll_pkg::EST_W-1:0];

endmodule

// ===== rtl/hyperloglog_cardinality_sketch.sv =====
// HyperLogLog sketch over 2^INDEX_BITS five-bit rank registers held in one
// single-port-read, single-port-write RAM. An add is taken in every cycle
// while busy is low; its read happens at the accepting edge and its write at
// the next, with the last write forwarded, so adds stream at one per cycle.
// A clear sweeps the RAM one entry a cycle (busy high), and the
// same pass runs once after reset before the first item is taken. A query
// walks the RAM one entry a cycle, then runs a bit-serial divide of 64 steps
// for the raw estimate; done pulses when it finishes. done
// is high for exactly one cycle with the result fields; there is no way to
// hold it off, so the receiver must take the beat when it appears.
module hyperloglog_cardinality_sketch (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    action,
    input  logic [31:0]                   hash,
    output logic                          done,
    output logic [hll_pkg::HSUM_W-1:0]    harmonic_sum,
    output logic [hll_pkg::ZOUT_W-1:0]    zero_count,
    output logic [hll_pkg::EST_W-1:0]     raw_estimate,
    output logic                          use_linear
);

    logic [hll_pkg::RANK_W-1:0] mem [hll_pkg::M];

    hll_pkg::state_t                 state_reg;
    hll_pkg::state_t                 state_next;
    logic [hll_pkg::INDEX_BITS-1:0]  addr_reg;
    logic [hll_pkg::INDEX_BITS-1:0]  addr_next;

    logic                            s1_valid_reg;
    logic [hll_pkg::INDEX_BITS-1:0]  s1_idx_reg;
    logic [hll_pkg::RANK_W-1:0]      s1_rank_reg;
    logic                            wb_valid_reg;
    logic [hll_pkg::INDEX_BITS-1:0]  wb_idx_reg;
    logic [hll_pkg::RANK_W-1:0]      wb_val_reg;
    logic [hll_pkg::RANK_W-1:0]      rd_data_reg;
    logic                            acc_valid_reg;
    logic [hll_pkg::SUM_W-1:0]       sum_reg;
    logic [hll_pkg::ZCNT_W-1:0]      zcnt_reg;

    logic                            done_reg;
    logic [hll_pkg::HSUM_W-1:0]      hsum_reg;
    logic [hll_pkg::ZOUT_W-1:0]      zout_reg;
    logic [hll_pkg::EST_W-1:0]       est_reg;
    logic                            lin_reg;

    logic                            accept;
    logic                            add_acc;
    logic                            query_acc;
    logic                            mem_re;
    logic [hll_pkg::INDEX_BITS-1:0]  mem_raddr;
    logic                            mem_we;
    logic [hll_pkg::INDEX_BITS-1:0]  mem_waddr;
    logic [hll_pkg::RANK_W-1:0]      mem_wdata;
    logic [hll_pkg::RANK_W-1:0]      old_rank;
    logic [hll_pkg::RANK_W-1:0]      new_rank;
    logic                            addr_last;
    logic                            div_start;
    logic                            div_done;
    logic [hll_pkg::EST_W-1:0]       div_quo;
    logic [hll_pkg::SUM_XW-1:0]      sum_x;
    logic [hll_pkg::ZCNT_XW-1:0]     zcnt_x;

    hll_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .den      (sum_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        busy      = state_reg != hll_pkg::ST_IDLE;
        accept    = start && !busy;
        add_acc   = accept && action == hll_pkg::ACT_ADD;
        query_acc = accept && action == hll_pkg::ACT_QUERY;
        addr_last = addr_reg == hll_pkg::INDEX_BITS'(hll_pkg::M - 1);

        mem_re    = add_acc || state_reg == hll_pkg::ST_WALK;
        mem_raddr = (state_reg == hll_pkg::ST_WALK) ? addr_reg
                                                    : hash[31 -: hll_pkg::INDEX_BITS];

        // forward the previous write when it hit the entry just read
        old_rank = (wb_valid_reg && wb_idx_reg == s1_idx_reg) ? wb_val_reg : rd_data_reg;
        new_rank = (s1_rank_reg > old_rank) ? s1_rank_reg : old_rank;

        mem_we    = state_reg == hll_pkg::ST_CLEAR || s1_valid_reg;
        mem_waddr = (state_reg == hll_pkg::ST_CLEAR) ? addr_reg : s1_idx_reg;
        mem_wdata = (state_reg == hll_pkg::ST_CLEAR) ? '0 : new_rank;

        sum_x  = hll_pkg::SUM_XW'(sum_reg);
        zcnt_x = hll_pkg::ZCNT_XW'(zcnt_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        div_start  = 1'b0;
        unique case (state_reg)
            hll_pkg::ST_CLEAR:
            begin
                addr_next = addr_reg + 1'b1;
                if (addr_last)
                    state_next = hll_pkg::ST_IDLE;
            end
            hll_pkg::ST_IDLE:
            begin
                addr_next = '0;
                if (accept && action == hll_pkg::ACT_QUERY)
                    state_next = hll_pkg::ST_WALK;
                else if (accept && action == hll_pkg::ACT_CLEAR)
                    state_next = hll_pkg::ST_CLEAR;
            end
            hll_pkg::ST_WALK:
            begin
                addr_next = addr_reg + 1'b1;
                if (addr_last)
                    state_next = hll_pkg::ST_LAST;
            end
            hll_pkg::ST_LAST:
                state_next = hll_pkg::ST_DSTART;
            hll_pkg::ST_DSTART:
            begin
                div_start  = 1'b1;
                state_next = hll_pkg::ST_DIV;
            end
            hll_pkg::ST_DIV:
            begin
                if (div_done)
                    state_next = hll_pkg::ST_IDLE;
            end
            default:
                state_next = hll_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hll_pkg::ST_CLEAR;
            addr_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            wb_valid_reg  <= 1'b0;
            acc_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            s1_valid_reg  <= add_acc;
            wb_valid_reg  <= s1_valid_reg;
            acc_valid_reg <= state_reg == hll_pkg::ST_WALK;
            done_reg      <= state_reg == hll_pkg::ST_DIV && div_done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (add_acc)
        begin
            s1_idx_reg  <= hash[31 -: hll_pkg::INDEX_BITS];
            s1_rank_reg <= hll_pkg::rank_of(hash);
        end
        if (s1_valid_reg)
        begin
            wb_idx_reg <= s1_idx_reg;
            wb_val_reg <= new_rank;
        end
        if (query_acc)
        begin
            sum_reg  <= '0;
            zcnt_reg <= '0;
        end
        else if (acc_valid_reg)
        begin
            sum_reg  <= sum_reg + hll_pkg::term_of(rd_data_reg);
            zcnt_reg <= zcnt_reg + hll_pkg::ZCNT_W'(rd_data_reg == '0);
        end
        if (state_reg == hll_pkg::ST_DIV && div_done)
        begin
            hsum_reg <= (sum_x > hll_pkg::SUM_XW'(hll_pkg::HSUM_MAX))
                        ? hll_pkg::HSUM_MAX : hll_pkg::HSUM_W'(sum_x);
            zout_reg <= (zcnt_x > hll_pkg::ZCNT_XW'(hll_pkg::ZOUT_MAX))
                        ? hll_pkg::ZOUT_MAX : hll_pkg::ZOUT_W'(zcnt_x);
            est_reg  <= div_quo;
            lin_reg  <= (div_quo <= hll_pkg::LIN_LIMIT) && zcnt_reg != '0;
        end
    end

    assign done         = done_reg;
    assign harmonic_sum = hsum_reg;
    assign zero_count   = zout_reg;
    assign raw_estimate = est_reg;
    assign use_linear   = lin_reg;

endmodule

// ===== rtl/hll_checker.sv =====
module hll_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic [1:0]                    action,
    input logic                          done,
    input logic [hll_pkg::ZOUT_W-1:0]    zero_count,
    input logic                          use_linear
);

    // a result beat is never followed at once by another
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result beat repeated");

    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && action == hll_pkg::ACT_QUERY) |=> busy)
        else $error("query beat did not raise busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && action == hll_pkg::ACT_CLEAR) |=> busy)
        else $error("clear beat did not raise busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && use_linear) |-> zero_count != '0)
        else $error("linear counting flagged with no zero registers");

endmodule

bind hyperloglog_cardinality_sketch hll_checker u_hll_checker (.*);
